>>> rtl/stp_pkg.sv
package stp_pkg;

  // Ring depth and sample format.
  localparam int unsigned DELAY_DEPTH = 262144;
  localparam int unsigned ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int unsigned FILL_W      = ADDR_W + 1;
  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned SUM_W       = SAMPLE_W + 2;

  // Register widths.
  localparam int unsigned IG_W   = 16;
  localparam int unsigned FB_W   = 15;
  localparam int unsigned BPM_W  = 8;
  localparam int unsigned RATE_W = 17;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // Width of 60 * sample_rate.
  localparam int unsigned NUM_W = RATE_W + 6;

  // Register reset values.
  localparam logic [IG_W-1:0]   IG_RST   = IG_W'(16384);
  localparam logic [FB_W-1:0]   FB_RST   = FB_W'(9830);
  localparam logic [BPM_W-1:0]  BPM_RST  = BPM_W'(80);
  localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(48000);

  // Delay lengths that follow from the reset tempo and rate.
  localparam int unsigned LEN_MAX    = DELAY_DEPTH - 1;
  localparam int unsigned BEAT_RST   = 60 * 48000 / 80;
  localparam int unsigned HALF_RST   = 60 * 48000 / 160;
  localparam int unsigned LEN_L_RST  = (BEAT_RST > LEN_MAX) ? LEN_MAX : BEAT_RST;
  localparam int unsigned LEN_R_RST  = (HALF_RST > LEN_MAX) ? LEN_MAX : HALF_RST;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_INPUT_GAIN    = 3'd0,
    REG_FEEDBACK_GAIN = 3'd1,
    REG_TEMPO_BPM     = 3'd2,
    REG_SAMPLE_RATE   = 3'd3,
    REG_MONO_SOURCE   = 3'd4
  } reg_idx_e;

  // Delay length divider states.
  typedef enum logic [1:0] {
    LEN_IDLE,
    LEN_LOAD,
    LEN_DIV
  } len_state_e;

  // Current register contents.
  typedef struct packed {
    logic [IG_W-1:0]   input_gain;
    logic [FB_W-1:0]   feedback_gain;
    logic [BPM_W-1:0]  tempo_bpm;
    logic [RATE_W-1:0] sample_rate;
    logic              mono_source;
  } cfg_t;

  // Pipeline control shared by both channels.
  typedef struct packed {
    logic acc;
    logic adv;
    logic s2_vld;
  } pipe_ctl_t;

endpackage

>>> rtl/stereo_tempo_feedback_delay.sv
// An accepted input beat passes through stage one, stage two and the output register before its result goes valid.
// Throughput: one stereo pair per cycle while nothing stalls, set by one write and one read port per channel memory.
// A tempo or rate write runs a bit-serial divider that holds off input while it is busy.
// Reset clears control state, restores register defaults and sets delays to 36000 and 18000.
// The echo memory is not cleared; a fill count makes slots never written read as zero.
module stereo_tempo_feedback_delay (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [stp_pkg::SAMPLE_W-1:0] left_sample_i,
  input  logic signed [stp_pkg::SAMPLE_W-1:0] right_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [stp_pkg::SAMPLE_W-1:0] left_out_o,
  output logic signed [stp_pkg::SAMPLE_W-1:0] right_out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stp_pkg::PADDR_W-1:0]         paddr,
  input  logic [stp_pkg::PDATA_W-1:0]         pwdata,
  output logic [stp_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  stp_pkg::cfg_t      cfg;
  stp_pkg::pipe_ctl_t ctl;

  logic                                cfg_wr, len_upd, len_busy;
  logic [stp_pkg::ADDR_W-1:0]          len_l, len_r;
  logic [stp_pkg::ADDR_W-1:0]          wp_q;
  logic [stp_pkg::FILL_W-1:0]          fill_q;
  logic                                s1_vld_q, s2_vld_q, out_vld_q;
  logic                                adv, acc;
  logic signed [stp_pkg::SAMPLE_W-1:0] dry_r, mix_l, mix_r;
  logic signed [stp_pkg::SAMPLE_W-1:0] out_l_q, out_r_q;

  stp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .wr_o    (cfg_wr),
    .upd_o   (len_upd)
  );

  stp_len u_len (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .upd_i         (len_upd),
    .tempo_bpm_i   (cfg.tempo_bpm),
    .sample_rate_i (cfg.sample_rate),
    .len_l_o       (len_l),
    .len_r_o       (len_r),
    .busy_o        (len_busy)
  );

  // The whole pipeline moves when the output register is free or being taken.
  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv || len_busy || cfg_wr;
  assign acc        = in_valid_i && !in_stall_o;

  assign ctl.acc    = acc;
  assign ctl.adv    = adv;
  assign ctl.s2_vld = s2_vld_q;

  // In mono mode the left input feeds the right channel.
  assign dry_r = cfg.mono_source ? left_sample_i : right_sample_i;

  stp_chan u_chan_l (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .dry_i           (left_sample_i),
    .wp_i            (wp_q),
    .len_i           (len_l),
    .fill_i          (fill_q),
    .input_gain_i    (cfg.input_gain),
    .feedback_gain_i (cfg.feedback_gain),
    .out_o           (mix_l)
  );

  stp_chan u_chan_r (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .dry_i           (dry_r),
    .wp_i            (wp_q),
    .len_i           (len_r),
    .fill_i          (fill_q),
    .input_gain_i    (cfg.input_gain),
    .feedback_gain_i (cfg.feedback_gain),
    .out_o           (mix_r)
  );

  // Write pointer, fill count and stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      fill_q    <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (acc) begin
        wp_q <= wp_q + 1'b1;
        if (fill_q != stp_pkg::FILL_W'(stp_pkg::DELAY_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (adv) begin
        s1_vld_q  <= acc;
        s2_vld_q  <= s1_vld_q;
        out_vld_q <= s2_vld_q;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_l_q <= mix_l;
      out_r_q <= mix_r;
    end
  end

  assign out_valid_o = out_vld_q;
  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;

endmodule

>>> rtl/stp_cfg.sv
module stp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [stp_pkg::PADDR_W-1:0]  paddr,
  input  logic [stp_pkg::PDATA_W-1:0]  pwdata,
  output logic [stp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output stp_pkg::cfg_t                cfg_o,
  output logic                         wr_o,
  output logic                         upd_o
);

  stp_pkg::cfg_t    cfg_q;
  stp_pkg::reg_idx_e idx;
  logic             wr;

  assign idx    = stp_pkg::reg_idx_e'(paddr[stp_pkg::PADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign wr_o   = wr;
  assign cfg_o  = cfg_q;

  // A tempo or rate write restarts the delay length computation.
  assign upd_o = wr && ((idx == stp_pkg::REG_TEMPO_BPM) || (idx == stp_pkg::REG_SAMPLE_RATE));

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.input_gain    <= stp_pkg::IG_RST;
      cfg_q.feedback_gain <= stp_pkg::FB_RST;
      cfg_q.tempo_bpm     <= stp_pkg::BPM_RST;
      cfg_q.sample_rate   <= stp_pkg::RATE_RST;
      cfg_q.mono_source   <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        stp_pkg::REG_INPUT_GAIN:    cfg_q.input_gain    <= pwdata[stp_pkg::IG_W-1:0];
        stp_pkg::REG_FEEDBACK_GAIN: cfg_q.feedback_gain <= pwdata[stp_pkg::FB_W-1:0];
        stp_pkg::REG_TEMPO_BPM:     cfg_q.tempo_bpm     <= pwdata[stp_pkg::BPM_W-1:0];
        stp_pkg::REG_SAMPLE_RATE:   cfg_q.sample_rate   <= pwdata[stp_pkg::RATE_W-1:0];
        stp_pkg::REG_MONO_SOURCE:   cfg_q.mono_source   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    unique case (idx)
      stp_pkg::REG_INPUT_GAIN:    prdata = stp_pkg::PDATA_W'(cfg_q.input_gain);
      stp_pkg::REG_FEEDBACK_GAIN: prdata = stp_pkg::PDATA_W'(cfg_q.feedback_gain);
      stp_pkg::REG_TEMPO_BPM:     prdata = stp_pkg::PDATA_W'(cfg_q.tempo_bpm);
      stp_pkg::REG_SAMPLE_RATE:   prdata = stp_pkg::PDATA_W'(cfg_q.sample_rate);
      stp_pkg::REG_MONO_SOURCE:   prdata = stp_pkg::PDATA_W'(cfg_q.mono_source);
      default:                    prdata = '0;
    endcase
  end

endmodule

>>> rtl/stp_len.sv
module stp_len (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        upd_i,
  input  logic [stp_pkg::BPM_W-1:0]   tempo_bpm_i,
  input  logic [stp_pkg::RATE_W-1:0]  sample_rate_i,
  output logic [stp_pkg::ADDR_W-1:0]  len_l_o,
  output logic [stp_pkg::ADDR_W-1:0]  len_r_o,
  output logic                        busy_o
);

  localparam int unsigned CNT_W = $clog2(stp_pkg::NUM_W);

  stp_pkg::len_state_e state_q, state_d;

  logic [stp_pkg::NUM_W-1:0]  num_q, num_d;
  logic [stp_pkg::BPM_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]           cnt_q;
  logic [stp_pkg::ADDR_W-1:0] len_l_q, len_r_q;
  logic [stp_pkg::BPM_W:0]    part, diff;
  logic                       ge;
  logic [stp_pkg::NUM_W-1:0]  beat, half;
  logic                       load_en, step_en, last;

  // Clamp a length to the ring.
  function automatic logic [stp_pkg::ADDR_W-1:0] clamp_len(input logic [stp_pkg::NUM_W-1:0] q);
    if (q > stp_pkg::NUM_W'(stp_pkg::LEN_MAX)) begin
      return stp_pkg::ADDR_W'(stp_pkg::LEN_MAX);
    end
    return q[stp_pkg::ADDR_W-1:0];
  endfunction

  // One restoring division step per cycle.
  assign part  = {rem_q, num_q[stp_pkg::NUM_W-1]};
  assign ge    = part >= {1'b0, tempo_bpm_i};
  assign diff  = part - {1'b0, tempo_bpm_i};
  assign rem_d = ge ? diff[stp_pkg::BPM_W-1:0] : part[stp_pkg::BPM_W-1:0];
  assign num_d = {num_q[stp_pkg::NUM_W-2:0], ge};
  assign last  = (cnt_q == '0);

  // Half a beat is the beat count halved.
  assign beat = num_d;
  assign half = num_d >> 1;

  // Next state. A new tempo or rate write restarts the division from any state.
  always_comb begin
    state_d = state_q;
    if (upd_i) begin
      state_d = stp_pkg::LEN_LOAD;
    end else begin
      unique case (state_q)
        stp_pkg::LEN_IDLE: state_d = stp_pkg::LEN_IDLE;
        stp_pkg::LEN_LOAD: state_d = (tempo_bpm_i == '0) ? stp_pkg::LEN_IDLE : stp_pkg::LEN_DIV;
        stp_pkg::LEN_DIV:  if (last) state_d = stp_pkg::LEN_IDLE;
        default:           state_d = stp_pkg::LEN_IDLE;
      endcase
    end
  end

  // State outputs.
  always_comb begin
    busy_o  = 1'b1;
    load_en = 1'b0;
    step_en = 1'b0;
    unique case (state_q)
      stp_pkg::LEN_IDLE: busy_o  = 1'b0;
      stp_pkg::LEN_LOAD: load_en = 1'b1;
      stp_pkg::LEN_DIV:  step_en = 1'b1;
      default:           busy_o  = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stp_pkg::LEN_IDLE;
      len_l_q <= stp_pkg::ADDR_W'(stp_pkg::LEN_L_RST);
      len_r_q <= stp_pkg::ADDR_W'(stp_pkg::LEN_R_RST);
    end else begin
      state_q <= state_d;
      if (load_en && (tempo_bpm_i == '0)) begin
        len_l_q <= stp_pkg::ADDR_W'(stp_pkg::LEN_MAX);
        len_r_q <= stp_pkg::ADDR_W'(stp_pkg::LEN_MAX);
      end else if (step_en && last) begin
        len_l_q <= clamp_len(beat);
        len_r_q <= clamp_len(half);
      end
    end
  end

  // Dividend is 60 * rate, formed as 64x - 4x.
  always_ff @(posedge clk_i) begin
    if (load_en) begin
      num_q <= (stp_pkg::NUM_W'(sample_rate_i) << 6) - (stp_pkg::NUM_W'(sample_rate_i) << 2);
      rem_q <= '0;
      cnt_q <= CNT_W'(stp_pkg::NUM_W - 1);
    end else if (step_en) begin
      num_q <= num_d;
      rem_q <= rem_d;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign len_l_o = len_l_q;
  assign len_r_o = len_r_q;

endmodule

>>> rtl/stp_chan.sv
module stp_chan (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  stp_pkg::pipe_ctl_t                 ctl_i,
  input  logic signed [stp_pkg::SAMPLE_W-1:0] dry_i,
  input  logic [stp_pkg::ADDR_W-1:0]         wp_i,
  input  logic [stp_pkg::ADDR_W-1:0]         len_i,
  input  logic [stp_pkg::FILL_W-1:0]         fill_i,
  input  logic [stp_pkg::IG_W-1:0]           input_gain_i,
  input  logic [stp_pkg::FB_W-1:0]           feedback_gain_i,
  output logic signed [stp_pkg::SAMPLE_W-1:0] out_o
);

  localparam int unsigned SW  = stp_pkg::SAMPLE_W;
  localparam int unsigned AW  = stp_pkg::ADDR_W;
  localparam int unsigned SMW = stp_pkg::SUM_W;
  localparam int unsigned P1W = SW + stp_pkg::IG_W + 1;
  localparam int unsigned P2W = SW + stp_pkg::FB_W + 1;

  // Echo memory for this channel.
  logic [SW-1:0] mem [stp_pkg::DELAY_DEPTH];

  // Stage one: dry sample, addresses and memory read data.
  logic signed [SW-1:0] dry1_q;
  logic [AW-1:0]        wp1_q, rp1_q;
  logic                 len0_q, wrt1_q;
  logic [SW-1:0]        rd_q;

  // Stage two: dry, level-scaled input and wet sample.
  logic signed [SW-1:0] dry2_q, w2_q, wet2_q;
  logic [AW-1:0]        wp2_q;

  // Last beat written to memory.
  logic                 wbv_q;
  logic [AW-1:0]        wba_q;
  logic signed [SW-1:0] wbd_q;

  logic [AW-1:0]         rp;
  logic signed [P1W-1:0] prod1;
  logic signed [SW-1:0]  w1, wet1, stored2;
  logic signed [P2W-1:0] prod2;
  logic signed [SMW-1:0] sum2, mix2;

  function automatic logic signed [SW-1:0] sat(input logic signed [SMW-1:0] v);
    if (v > SMW'($signed({1'b0, {(SW-1){1'b1}}}))) begin
      return {1'b0, {(SW-1){1'b1}}};
    end
    if (v < SMW'($signed({1'b1, {(SW-1){1'b0}}}))) begin
      return {1'b1, {(SW-1){1'b0}}};
    end
    return v[SW-1:0];
  endfunction

  assign rp = wp_i - len_i;

  // Stage one: input times level, then pick the wet sample from the newest source.
  assign prod1 = P1W'(dry1_q) * $signed({1'b0, input_gain_i});
  assign w1    = sat(prod1[P1W-1:15]);

  always_comb begin
    if (len0_q) begin
      wet1 = w1;
    end else if (ctl_i.s2_vld && (wp2_q == rp1_q)) begin
      wet1 = stored2;
    end else if (wbv_q && (wba_q == rp1_q)) begin
      wet1 = wbd_q;
    end else if (wrt1_q) begin
      wet1 = $signed(rd_q);
    end else begin
      wet1 = '0;
    end
  end

  // Stage two: feedback into memory and dry plus wet to the output.
  assign prod2   = P2W'(wet2_q) * $signed({1'b0, feedback_gain_i});
  assign sum2    = SMW'(w2_q) + SMW'($signed(prod2[P2W-1:15]));
  assign stored2 = sat(sum2);
  assign mix2    = SMW'(dry2_q) + SMW'(wet2_q);
  assign out_o   = sat(mix2);

  // Memory: write the finished slot, read the delayed slot on acceptance.
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv && ctl_i.s2_vld) begin
      mem[wp2_q] <= stored2;
    end
    if (ctl_i.acc) begin
      rd_q <= mem[rp];
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (ctl_i.acc) begin
      dry1_q <= dry_i;
      wp1_q  <= wp_i;
      rp1_q  <= rp;
      len0_q <= (len_i == '0);
      wrt1_q <= ({1'b0, rp} < fill_i);
    end
    if (ctl_i.adv) begin
      dry2_q <= dry1_q;
      w2_q   <= w1;
      wet2_q <= wet1;
      wp2_q  <= wp1_q;
      wba_q  <= wp2_q;
      wbd_q  <= stored2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wbv_q <= 1'b0;
    end else if (ctl_i.adv) begin
      wbv_q <= ctl_i.s2_vld;
    end
  end

endmodule
